// ===== hdl/pure_pursuit_steering_defines.svh =====
// ----------------------------------------------------------------------------
// pure pursuit steering assertion macros
// Concurrent check wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PURE_PURSUIT_STEERING_DEFINES_SVH
`define PURE_PURSUIT_STEERING_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PPST_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ppst check failed");
`define PPST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error("ppst sequence check failed");
`else
`define PPST_ASSERT(label, prop)
`define PPST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/ppst_pkg.sv =====
// ----------------------------------------------------------------------------
// ppst_pkg
// Shared constants, types and helper functions of the pure pursuit block.
// ----------------------------------------------------------------------------
package ppst_pkg;

    localparam int MAX_PTS    = 256;
    localparam int IDX_W      = $clog2(MAX_PTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int DIV_W      = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [63:0] NEAR_LIMIT = 64'd4294967;
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOK_AHEAD  = 2'd0,
        CFG_MAX_LINEAR  = 2'd1,
        CFG_MAX_ANGULAR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic div_load;
        logic div_step;
    } t_alu_ctl;

    typedef struct packed {
        logic [15:0]        lin;
        logic signed [31:0] ang;
        logic [7:0]         car;
        logic               st;
    } t_res;

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m[31:0];
    endfunction

    function automatic logic signed [65:0] sgn66(input logic [63:0] p, input logic neg);
        logic signed [65:0] e;
        e = signed'({2'b00, p});
        return neg ? -e : e;
    endfunction

    // divide by 2^30 toward zero, then clamp to 32 bits
    function automatic logic signed [31:0] tsat(input logic signed [65:0] v);
        logic signed [65:0] t;
        logic signed [65:0] sh;
        t  = v[65] ? v + 66'sd1073741823 : v;
        sh = t >>> 30;
        if (sh > 66'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (sh < -66'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return signed'(sh[31:0]);
    endfunction

endpackage

// ===== hdl/ppst_if.sv =====
// ----------------------------------------------------------------------------
// ppst interfaces
// Valid/ready channels for points and queries, commands and configuration.
// ----------------------------------------------------------------------------
interface ppst_pt_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               new_path;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, kind, new_path, pos_x, pos_y, quat_z, quat_w,
                    input ready);
    modport sink   (input valid, kind, new_path, pos_x, pos_y, quat_z, quat_w,
                    output ready);
endinterface

interface ppst_cmd_if;
    logic               valid;
    logic               ready;
    logic [15:0]        linear_cmd;
    logic signed [31:0] angular_cmd;
    logic [7:0]         carrot_index;
    logic               status;
    modport source (output valid, linear_cmd, angular_cmd, carrot_index, status,
                    input ready);
    modport sink   (input valid, linear_cmd, angular_cmd, carrot_index, status,
                    output ready);
endinterface

interface ppst_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [30:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/ppst_mem.sv =====
// ----------------------------------------------------------------------------
// ppst_mem
// Path point store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ppst_mem
    import ppst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [63:0]      i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [63:0]      o_rdata
);

    logic [63:0] r_mem [MAX_PTS];
    logic [63:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

// ===== hdl/ppst_alu.sv =====
// ----------------------------------------------------------------------------
// ppst_alu
// Shared 32x32 multiplier and restoring divider, one quotient bit per cycle while div_step is set.
// ----------------------------------------------------------------------------
module ppst_alu
    import ppst_pkg::*;
(
    input  logic             i_clk,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    input  t_alu_ctl         i_ctl,
    input  logic [DIV_W-1:0] i_dvd,
    input  logic [DIV_W-1:0] i_dvs,
    output logic [63:0]      o_prod,
    output logic [DIV_W-1:0] o_quo
);

    logic [63:0]      r_prod;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W:0]   w_shift;
    logic             w_fit;

    // remainder stays below the divisor, so one extra bit covers the shift
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.div_load) begin
            r_rem <= '0;
            r_quo <= i_dvd;
            r_dvs <= i_dvs;
        end else if (i_ctl.div_step) begin
            r_rem <= w_fit ? DIV_W'(w_shift - {1'b0, r_dvs}) : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_prod = r_prod;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/pure_pursuit_steering.sv =====
// ----------------------------------------------------------------------------
// pure_pursuit_steering: a point load is taken in the idle state; a query scans the stored
// points from the last one back, then runs up to three divisions on the shared unit
// and may wait on the output; an empty path answers with status set and no scan,
// one transaction at a time; synchronous active-low reset empties the path and resets config
// ----------------------------------------------------------------------------
`include "pure_pursuit_steering_defines.svh"

module pure_pursuit_steering
    import ppst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppst_pt_if.sink     i_pt,
    ppst_cmd_if.source  o_cmd,
    ppst_cfg_if.sink    i_cfg
);

    typedef enum logic [26:0] {
        S_IDLE = 27'h0000001,
        S_LA   = 27'h0000002,
        S_RD   = 27'h0000004,
        S_DX   = 27'h0000008,
        S_MX   = 27'h0000010,
        S_MY   = 27'h0000020,
        S_CMP  = 27'h0000040,
        S_Q1   = 27'h0000080,
        S_Q2   = 27'h0000100,
        S_Q3   = 27'h0000200,
        S_Q4   = 27'h0000400,
        S_DIVC = 27'h0000800,
        S_CQ   = 27'h0001000,
        S_DIVS = 27'h0002000,
        S_SQ   = 27'h0004000,
        S_R1   = 27'h0008000,
        S_R2   = 27'h0010000,
        S_R3   = 27'h0020000,
        S_R4   = 27'h0040000,
        S_R5   = 27'h0080000,
        S_D1   = 27'h0100000,
        S_D2   = 27'h0200000,
        S_D3   = 27'h0400000,
        S_D4   = 27'h0800000,
        S_DIVA = 27'h1000000,
        S_ANG  = 27'h2000000,
        S_DONE = 27'h4000000
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic [IDX_W-1:0]     carrot;
        logic                 first;
        logic signed [31:0]   px;
        logic signed [31:0]   py;
        logic signed [15:0]   qz;
        logic signed [15:0]   qw;
        logic [63:0]          la2;
        logic signed [32:0]   dx;
        logic signed [32:0]   dy;
        logic signed [32:0]   cdx;
        logic signed [32:0]   cdy;
        logic [63:0]          acc;
        logic [31:0]          w2;
        logic [31:0]          z2;
        logic [31:0]          wz;
        logic [30:0]          cmag;
        logic [30:0]          smag;
        logic                 cneg;
        logic                 sneg;
        logic signed [65:0]   accx;
        logic signed [31:0]   xr;
        logic signed [31:0]   yr;
        logic [DIV_CNT_W-1:0] cnt;
        t_res                 res;
    } t_work;

    t_state r_state, n_state;
    t_work  r_w, n_w;
    logic [CNT_W-1:0] r_count, n_count;
    logic   r_ov, n_ov;
    t_res   r_out, n_out;

    logic [30:0] r_la;
    logic [15:0] r_lin;
    logic [15:0] r_angk;

    logic             w_acc;
    logic             w_load;
    logic             w_grow;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [63:0]      w_rdata;
    logic [31:0]      w_mul_a, w_mul_b;
    logic [63:0]      w_prod;
    t_alu_ctl         w_ctl;
    logic [DIV_W-1:0] w_dvd, w_dvs, w_quo;
    logic [63:0]      w_sum;
    logic             w_far;
    logic             w_beyond;
    logic [31:0]      w_n;
    logic [31:0]      w_diff;

    assign w_acc   = i_pt.valid && i_pt.ready;
    assign w_load  = w_acc && !i_pt.kind;
    assign w_grow  = w_load && !i_pt.new_path && (r_count < CNT_W'(MAX_PTS));
    assign w_we    = w_load && (i_pt.new_path || (r_count < CNT_W'(MAX_PTS)));
    assign w_waddr = i_pt.new_path ? '0 : r_count[IDX_W-1:0];

    ppst_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({i_pt.pos_x, i_pt.pos_y}),
        .i_raddr (r_w.idx),
        .o_rdata (w_rdata)
    );

    ppst_alu u_alu (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .i_ctl  (w_ctl),
        .i_dvd  (w_dvd),
        .i_dvs  (w_dvs),
        .o_prod (w_prod),
        .o_quo  (w_quo)
    );

    assign w_sum    = r_w.acc + w_prod;
    assign w_far    = mag33(r_w.dx) >= 32'h8000_0000 || mag33(r_w.dy) >= 32'h8000_0000;
    assign w_beyond = w_far || (w_sum > r_w.la2);
    assign w_n      = r_w.w2 + r_w.z2;
    assign w_diff   = (r_w.w2 >= r_w.z2) ? r_w.w2 - r_w.z2 : r_w.z2 - r_w.w2;

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        n_count = r_count;
        n_ov    = r_ov;
        n_out   = r_out;
        w_mul_a = '0;
        w_mul_b = '0;
        w_ctl   = '0;
        w_dvd   = '0;
        w_dvs   = '0;

        if (o_cmd.valid && o_cmd.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_load) begin
                    if (i_pt.new_path) begin
                        n_count = CNT_W'(1);
                    end else if (r_count < CNT_W'(MAX_PTS)) begin
                        n_count = r_count + 1'b1;
                    end
                end else if (w_acc) begin
                    n_w.px = i_pt.pos_x;
                    n_w.py = i_pt.pos_y;
                    n_w.qz = i_pt.quat_z;
                    n_w.qw = i_pt.quat_w;
                    if (r_count == '0) begin
                        n_w.res = '{lin: '0, ang: '0, car: '0, st: 1'b1};
                        n_state = S_DONE;
                    end else begin
                        n_w.idx    = IDX_W'(r_count - 1'b1);
                        n_w.carrot = IDX_W'(r_count - 1'b1);
                        n_w.first  = 1'b1;
                        n_state    = S_LA;
                    end
                end
            end
            S_LA: begin
                w_mul_a = {1'b0, r_la};
                w_mul_b = {1'b0, r_la};
                n_state = S_RD;
            end
            S_RD: begin
                if (r_w.first) begin
                    n_w.la2 = w_prod;
                end
                n_state = S_DX;
            end
            S_DX: begin
                n_w.dx  = {w_rdata[63], w_rdata[63:32]} - {r_w.px[31], r_w.px};
                n_w.dy  = {w_rdata[31], w_rdata[31:0]} - {r_w.py[31], r_w.py};
                n_state = S_MX;
            end
            S_MX: begin
                w_mul_a = mag33(r_w.dx);
                w_mul_b = mag33(r_w.dx);
                n_state = S_MY;
            end
            S_MY: begin
                n_w.acc = w_prod;
                w_mul_a = mag33(r_w.dy);
                w_mul_b = mag33(r_w.dy);
                n_state = S_CMP;
            end
            S_CMP: begin
                // carrot is the last beyond point, or the final point when it is near
                if (w_beyond || r_w.first) begin
                    n_w.carrot = r_w.idx;
                    n_w.cdx    = r_w.dx;
                    n_w.cdy    = r_w.dy;
                end
                n_w.first = 1'b0;
                if (w_beyond && r_w.idx != '0) begin
                    n_w.idx = r_w.idx - 1'b1;
                    n_state = S_RD;
                end else begin
                    n_state = S_Q1;
                end
            end
            S_Q1: begin
                w_mul_a = 32'(mag16(r_w.qw));
                w_mul_b = 32'(mag16(r_w.qw));
                n_state = S_Q2;
            end
            S_Q2: begin
                n_w.w2  = w_prod[31:0];
                w_mul_a = 32'(mag16(r_w.qz));
                w_mul_b = 32'(mag16(r_w.qz));
                n_state = S_Q3;
            end
            S_Q3: begin
                n_w.z2  = w_prod[31:0];
                w_mul_a = 32'(mag16(r_w.qw));
                w_mul_b = 32'(mag16(r_w.qz));
                n_state = S_Q4;
            end
            S_Q4: begin
                n_w.wz = w_prod[31:0];
                if (w_n == '0) begin
                    // zero quaternion rotates by nothing
                    n_w.cmag = ONE_Q30;
                    n_w.cneg = 1'b0;
                    n_w.smag = '0;
                    n_w.sneg = 1'b0;
                    n_state  = S_R1;
                end else begin
                    w_ctl.div_load = 1'b1;
                    w_dvd    = {2'b00, w_diff, 30'b0};
                    w_dvs    = {32'b0, w_n};
                    n_w.cneg = r_w.z2 > r_w.w2;
                    n_w.cnt  = '0;
                    n_state  = S_DIVC;
                end
            end
            S_DIVC: begin
                w_ctl.div_step = 1'b1;
                n_w.cnt = r_w.cnt + 1'b1;
                if (r_w.cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    n_state = S_CQ;
                end
            end
            S_CQ: begin
                n_w.cmag = w_quo[30:0];
                w_ctl.div_load = 1'b1;
                w_dvd    = {1'b0, r_w.wz, 31'b0};
                w_dvs    = {32'b0, w_n};
                n_w.sneg = r_w.qw[15] ^ r_w.qz[15];
                n_state  = S_DIVS;
            end
            S_DIVS: begin
                w_ctl.div_step = 1'b1;
                n_w.cnt = r_w.cnt + 1'b1;
                if (r_w.cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_w.smag = w_quo[30:0];
                n_state  = S_R1;
            end
            S_R1: begin
                w_mul_a = {1'b0, r_w.cmag};
                w_mul_b = mag33(r_w.cdx);
                n_state = S_R2;
            end
            S_R2: begin
                n_w.accx = sgn66(w_prod, r_w.cneg ^ r_w.cdx[32]);
                w_mul_a  = {1'b0, r_w.smag};
                w_mul_b  = mag33(r_w.cdy);
                n_state  = S_R3;
            end
            S_R3: begin
                n_w.accx = r_w.accx + sgn66(w_prod, r_w.sneg ^ r_w.cdy[32]);
                w_mul_a  = {1'b0, r_w.cmag};
                w_mul_b  = mag33(r_w.cdy);
                n_state  = S_R4;
            end
            S_R4: begin
                n_w.xr   = tsat(r_w.accx);
                n_w.accx = sgn66(w_prod, r_w.cneg ^ r_w.cdy[32]);
                w_mul_a  = {1'b0, r_w.smag};
                w_mul_b  = mag33(r_w.cdx);
                n_state  = S_R5;
            end
            S_R5: begin
                n_w.yr  = tsat(r_w.accx - sgn66(w_prod, r_w.sneg ^ r_w.cdx[32]));
                n_state = S_D1;
            end
            S_D1: begin
                w_mul_a = mag32(r_w.xr);
                w_mul_b = mag32(r_w.xr);
                n_state = S_D2;
            end
            S_D2: begin
                n_w.acc = w_prod;
                w_mul_a = mag32(r_w.yr);
                w_mul_b = mag32(r_w.yr);
                n_state = S_D3;
            end
            S_D3: begin
                n_w.acc = w_sum;
                w_mul_a = mag32(r_w.yr);
                w_mul_b = {16'b0, r_angk};
                n_state = S_D4;
            end
            S_D4: begin
                if (r_w.acc <= NEAR_LIMIT) begin
                    n_w.res = '{lin: r_lin, ang: '0, car: 8'(r_w.carrot), st: 1'b0};
                    n_state = S_DONE;
                end else begin
                    w_ctl.div_load = 1'b1;
                    w_dvd   = {w_prod[46:0], 17'b0};
                    w_dvs   = r_w.acc;
                    n_w.cnt = '0;
                    n_state = S_DIVA;
                end
            end
            S_DIVA: begin
                w_ctl.div_step = 1'b1;
                n_w.cnt = r_w.cnt + 1'b1;
                if (r_w.cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    n_state = S_ANG;
                end
            end
            S_ANG: begin
                n_w.res.lin = r_lin;
                n_w.res.car = 8'(r_w.carrot);
                n_w.res.st  = 1'b0;
                if (r_w.yr[31]) begin
                    n_w.res.ang = (w_quo > 64'h8000_0000) ? 32'sh8000_0000
                                                          : signed'(32'(-w_quo));
                end else begin
                    n_w.res.ang = (w_quo > 64'h7fff_ffff) ? 32'sh7fff_ffff
                                                          : signed'(w_quo[31:0]);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_cmd.ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_w.res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
        r_w   <= n_w;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la   <= 31'd32768;
            r_lin  <= 16'd1229;
            r_angk <= 16'd4096;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_LOOK_AHEAD:  r_la   <= i_cfg.data;
                CFG_MAX_LINEAR:  r_lin  <= i_cfg.data[15:0];
                CFG_MAX_ANGULAR: r_angk <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign i_pt.ready         = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_cmd.valid        = r_ov;
    assign o_cmd.linear_cmd   = r_out.lin;
    assign o_cmd.angular_cmd  = r_out.ang;
    assign o_cmd.carrot_index = r_out.car;
    assign o_cmd.status       = r_out.st;

    `PPST_ASSERT(a_count_max, r_count <= CNT_W'(MAX_PTS))
    `PPST_ASSERT_NEXT(a_load_inc, w_grow, r_count == $past(r_count) + 1'b1)
    `PPST_ASSERT(a_div_safe, (r_state != S_DIVA) || (r_w.acc > NEAR_LIMIT))

endmodule
